@@ hw/rtl/mbb_pkg.sv @@
// Shared constants and register codes for the mask bounding box unit.
`default_nettype none

package mbb_pkg;

   localparam int PIXEL_W      = 8;
   localparam int BOX_W        = 11;
   localparam int DIM_REG_W    = 12;
   localparam int EXT_REG_W    = 11;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT    = 2'd1,
      CSR_EXTEND_PIXELS   = 2'd2,
      CSR_EMPTY_ON_BORDER = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

@@ hw/rtl/mask_bounding_box_unit.sv @@
// Mask bounding box unit: tracks set pixels of a raster mask and reports one box per frame.
// Throughput: one pixel per cycle; pixels are taken while a finished box waits on rsp_.
// The box reaches rsp_ by way of the frame-end capture register, loaded as the frame's last pixel
// is accepted, then the result register, loaded once rsp_ is free.
// req_ready drops only while a captured box and a waiting result both stall.
// Synchronous reset: registers return to 640x480, no margin, border rule off, frame restarted.
`default_nettype none

module mask_bounding_box_unit
   import mbb_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [BOX_W-1:0]           rsp_box_x,
   output logic [BOX_W-1:0]           rsp_box_y,
   output logic [BOX_W-1:0]           rsp_box_width,
   output logic [BOX_W-1:0]           rsp_box_height,
   output logic                       rsp_box_empty,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WDW = $clog2(MAX_WIDTH + 1);
   localparam int HDW = $clog2(MAX_HEIGHT + 1);
   localparam int XSW = ((CW > EXT_REG_W) ? CW : EXT_REG_W) + 1;
   localparam int YSW = ((RW > EXT_REG_W) ? RW : EXT_REG_W) + 1;

   // ---------------------------------------------------------------- registers
   logic [DIM_REG_W-1:0] frame_width_ff, frame_width_in;
   logic [DIM_REG_W-1:0] frame_height_ff, frame_height_in;
   logic [EXT_REG_W-1:0] extend_ff, extend_in;
   logic                 border_ff, border_in;

   logic                 csr_wr;
   logic                 restart;
   csr_index_type        csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[3:2]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      extend_in       = extend_ff;
      border_in       = border_ff;
      restart         = 1'b0;
      if (csr_wr) begin
         case (csr_idx)
            CSR_FRAME_WIDTH: begin
               frame_width_in = pwdata[DIM_REG_W-1:0];
               restart        = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = pwdata[DIM_REG_W-1:0];
               restart         = 1'b1;
            end
            CSR_EXTEND_PIXELS:   extend_in = pwdata[EXT_REG_W-1:0];
            CSR_EMPTY_ON_BORDER: border_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_FRAME_WIDTH:     prdata = CSR_DATA_W'(frame_width_ff);
         CSR_FRAME_HEIGHT:    prdata = CSR_DATA_W'(frame_height_ff);
         CSR_EXTEND_PIXELS:   prdata = CSR_DATA_W'(extend_ff);
         CSR_EMPTY_ON_BORDER: prdata = CSR_DATA_W'(border_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         extend_ff       <= '0;
         border_ff       <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         extend_ff       <= extend_in;
         border_ff       <= border_in;
      end
   end

   // geometry clamped to 2 .. MAX, held as last index
   logic [WDW-1:0] eff_w;
   logic [HDW-1:0] eff_h;
   logic [CW-1:0]  w_m1;
   logic [RW-1:0]  h_m1;

   always_comb begin
      if (frame_width_ff < DIM_REG_W'(2))  eff_w = WDW'(2);
      else if (frame_width_ff > MAX_WIDTH) eff_w = WDW'(MAX_WIDTH);
      else                                 eff_w = WDW'(frame_width_ff);
      if (frame_height_ff < DIM_REG_W'(2))   eff_h = HDW'(2);
      else if (frame_height_ff > MAX_HEIGHT) eff_h = HDW'(MAX_HEIGHT);
      else                                   eff_h = HDW'(frame_height_ff);
      w_m1 = CW'(eff_w - WDW'(1));
      h_m1 = RW'(eff_h - HDW'(1));
   end

   // ---------------------------------------------------------------- handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic fin_valid_ff, fin_valid_in;
   logic out_free, fin_adv, accept, last_col, last_row, frame_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_adv   = fin_valid_ff && out_free;
   assign req_ready = !fin_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- tracking
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          seen_ff, seen_in;
   logic [RW-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [CW-1:0] left_ff, left_in, right_ff, right_in;
   logic          pix_set;

   assign pix_set  = (req_pixel != '0);
   assign last_col = (col_ff >= w_m1);
   assign last_row = (row_ff >= h_m1);
   assign frame_end = accept && last_col && last_row;

   // tracker values including the pixel being taken; seen flag stands in
   // for the "min = frame size" start value
   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      seen_in   = seen_ff;
      if (pix_set) begin
         if (!seen_ff || row_ff < top_ff)    top_in    = row_ff;
         if (!seen_ff || row_ff > bottom_ff) bottom_in = row_ff;
         if (!seen_ff || col_ff < left_ff)   left_in   = col_ff;
         if (!seen_ff || col_ff > right_ff)  right_in  = col_ff;
         seen_in = 1'b1;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (!last_col) begin
         col_in = col_ff + CW'(1);
      end else if (!last_row) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= 1'b0;
      end else if (restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= 1'b0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         seen_ff <= frame_end ? 1'b0 : seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   // ---------------------------------------------------------------- frame-end capture
   logic [RW-1:0] fin_top_ff, fin_bottom_ff;
   logic [CW-1:0] fin_left_ff, fin_right_ff;
   logic          fin_seen_ff;

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (frame_end)    fin_valid_in = 1'b1;
      else if (fin_adv) fin_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) fin_valid_ff <= 1'b0;
      else       fin_valid_ff <= fin_valid_in;
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         fin_top_ff    <= top_in;
         fin_bottom_ff <= bottom_in;
         fin_left_ff   <= left_in;
         fin_right_ff  <= right_in;
         fin_seen_ff   <= seen_in;
      end
   end

   // ---------------------------------------------------------------- box build
   logic          raw_empty, box_empty;
   logic [CW-1:0] left_e, right_e;
   logic [RW-1:0] top_e, bottom_e;
   logic [XSW-1:0] right_sum;
   logic [YSW-1:0] bottom_sum;

   always_comb begin
      raw_empty = !fin_seen_ff || (fin_top_ff >= fin_bottom_ff) ||
                  (fin_left_ff >= fin_right_ff);

      if (XSW'(fin_left_ff) > XSW'(extend_ff))
         left_e = CW'(XSW'(fin_left_ff) - XSW'(extend_ff));
      else
         left_e = '0;
      if (YSW'(fin_top_ff) > YSW'(extend_ff))
         top_e = RW'(YSW'(fin_top_ff) - YSW'(extend_ff));
      else
         top_e = '0;

      right_sum  = XSW'(fin_right_ff) + XSW'(extend_ff);
      bottom_sum = YSW'(fin_bottom_ff) + YSW'(extend_ff);
      right_e    = (right_sum < XSW'(w_m1))  ? CW'(right_sum)  : w_m1;
      bottom_e   = (bottom_sum < YSW'(h_m1)) ? RW'(bottom_sum) : h_m1;

      box_empty = raw_empty ||
                  (border_ff && ((left_e == '0) || (top_e == '0) ||
                                 (right_e == w_m1) || (bottom_e == h_m1)));
   end

   // ---------------------------------------------------------------- result register
   logic [BOX_W-1:0] box_x_ff, box_y_ff, box_width_ff, box_height_ff;
   logic             box_empty_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_adv)        rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (fin_adv) begin
         box_empty_ff <= box_empty;
         if (box_empty) begin
            box_x_ff      <= '0;
            box_y_ff      <= '0;
            box_width_ff  <= '0;
            box_height_ff <= '0;
         end else begin
            box_x_ff      <= BOX_W'(left_e);
            box_y_ff      <= BOX_W'(top_e);
            box_width_ff  <= BOX_W'(right_e - left_e);
            box_height_ff <= BOX_W'(bottom_e - top_e);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_x      = box_x_ff;
   assign rsp_box_y      = box_y_ff;
   assign rsp_box_width  = box_width_ff;
   assign rsp_box_height = box_height_ff;
   assign rsp_box_empty  = box_empty_ff;

   // ---------------------------------------------------------------- assertions
   a_counters_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= w_m1) && (row_ff <= h_m1))
      else $error("pixel counters ran past the frame");

   a_frame_end_captured: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> fin_valid_ff)
      else $error("frame end not captured");

   a_capture_held: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !out_free) |=> (fin_valid_ff && $stable(fin_left_ff) &&
                                       $stable(fin_top_ff)))
      else $error("stalled frame-end capture lost");

   a_empty_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && box_empty_ff) |-> ((box_x_ff == '0) && (box_y_ff == '0) &&
                                          (box_width_ff == '0) && (box_height_ff == '0)))
      else $error("empty box carries nonzero fields");

endmodule

`default_nettype wire

@@ test/tb_mask_bounding_box_unit.sv @@
// Self-checking testbench for the mask bounding box unit: directed frames, then random phases.
`timescale 1ns / 100ps

module tb_mask_bounding_box_unit;
   import mbb_pkg::*;

   localparam int DIM_LIMIT     = 2048;
   localparam int WIDE_DIM      = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 800;

   typedef struct packed {
      logic [BOX_W-1:0] x;
      logic [BOX_W-1:0] y;
      logic [BOX_W-1:0] w;
      logic [BOX_W-1:0] h;
      logic             empty;
   } mask_box_type;

   typedef enum logic [1:0] {STEP_READ, STEP_WRITE, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      csr_index_type target;
      logic [11:0]   value;
      logic          typed;
      mask_box_type  box;
   } step_type;

   localparam mask_box_type NO_BOX    = '0;
   localparam mask_box_type EMPTY_BOX = '{x: '0, y: '0, w: '0, h: '0, empty: 1'b1};
   localparam mask_box_type UNIT_BOX  = '{x: '0, y: '0, w: 11'd1, h: 11'd1, empty: 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BOX_W-1:0]      rsp_box_x;
   logic [BOX_W-1:0]      rsp_box_y;
   logic [BOX_W-1:0]      rsp_box_width;
   logic [BOX_W-1:0]      rsp_box_height;
   logic                  rsp_box_empty;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // register copies and frame trackers of the predictor
   logic [DIM_REG_W-1:0] cfg_frame_w = FRAME_WIDTH_RST;
   logic [DIM_REG_W-1:0] cfg_frame_h = FRAME_HEIGHT_RST;
   logic [EXT_REG_W-1:0] cfg_extend  = '0;
   logic                 cfg_border  = 1'b0;
   int col_pos, row_pos, top_row, bottom_row, left_col, right_col;

   mask_box_type pending_boxes[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int stall_left     = 0;
   int error_count    = 0;
   int boxes_checked  = 0;
   int items_sent     = 0;
   int phases_run     = 0;

   // frame content generator
   bit shape_noise;
   int noise_pct, fill_pct, stray_pct;
   int blob_r0, blob_r1, blob_c0, blob_c1;
   int forced_noise_pct = -1;

   step_type directed_steps [34] = '{
      '{STEP_READ,  CSR_FRAME_WIDTH,     12'd640,  1'b1, NO_BOX},
      '{STEP_READ,  CSR_FRAME_HEIGHT,    12'd480,  1'b1, NO_BOX},
      '{STEP_READ,  CSR_EXTEND_PIXELS,   12'd0,    1'b1, NO_BOX},
      '{STEP_READ,  CSR_EMPTY_ON_BORDER, 12'd0,    1'b1, NO_BOX},
      // undersized geometry, clamps to 2x2
      '{STEP_WRITE, CSR_FRAME_WIDTH,     12'd1,    1'b0, NO_BOX},
      '{STEP_WRITE, CSR_FRAME_HEIGHT,    12'd0,    1'b0, NO_BOX},
      '{STEP_READ,  CSR_FRAME_WIDTH,     12'd1,    1'b1, NO_BOX},
      // blank frame
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b1, EMPTY_BOX},
      // full frame
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b1, UNIT_BOX},
      // widest margin, clamped back to the frame
      '{STEP_WRITE, CSR_EXTEND_PIXELS,   12'd2047, 1'b0, NO_BOX},
      '{STEP_READ,  CSR_EXTEND_PIXELS,   12'd2047, 1'b1, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h001,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h080,  1'b1, UNIT_BOX},
      // set pixels in one row only
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h040,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h002,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b1, EMPTY_BOX},
      // set pixels in one column only
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h010,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h004,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h000,  1'b1, EMPTY_BOX},
      // border rule on a box touching every edge
      '{STEP_WRITE, CSR_EMPTY_ON_BORDER, 12'd1,    1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b0, NO_BOX},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,     12'h0FF,  1'b1, EMPTY_BOX}
   };

   mask_bounding_box_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_y      (rsp_box_y),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_box_empty  (rsp_box_empty),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_mask_bounding_box_unit: FAIL");
      $finish;
   end

   function automatic int eff_dim(input logic [DIM_REG_W-1:0] v);
      if (v < 2) return 2;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
   endfunction

   function automatic void restart_tracking();
      col_pos    = 0;
      row_pos    = 0;
      top_row    = eff_dim(cfg_frame_h);
      bottom_row = 0;
      left_col   = eff_dim(cfg_frame_w);
      right_col  = 0;
   endfunction

   // Advances the frame trackers by one pixel; returns 1 with the box at the frame end.
   function automatic bit predict_pixel(input logic [PIXEL_W-1:0] px,
                                        output mask_box_type box);
      int w, h, ext, top, bottom, left, right;
      bit no_box;
      w   = eff_dim(cfg_frame_w);
      h   = eff_dim(cfg_frame_h);
      ext = cfg_extend;
      box = '0;
      if (px != '0) begin
         if (row_pos < top_row) top_row = row_pos;
         if (row_pos > bottom_row) bottom_row = row_pos;
         if (col_pos < left_col) left_col = col_pos;
         if (col_pos > right_col) right_col = col_pos;
      end
      if (col_pos + 1 < w) begin
         col_pos++;
         return 1'b0;
      end
      if (row_pos + 1 < h) begin
         col_pos = 0;
         row_pos++;
         return 1'b0;
      end
      top    = top_row;
      bottom = bottom_row;
      left   = left_col;
      right  = right_col;
      no_box = (top >= bottom) || (left >= right);
      if (!no_box) begin
         left   = (left > ext) ? left - ext : 0;
         top    = (top > ext) ? top - ext : 0;
         right  = (right + ext < w - 1) ? right + ext : w - 1;
         bottom = (bottom + ext < h - 1) ? bottom + ext : h - 1;
         if (cfg_border && (left == 0 || top == 0 || right == w - 1 || bottom == h - 1))
            no_box = 1'b1;
      end
      if (no_box) begin
         box.empty = 1'b1;
      end else begin
         box.x = BOX_W'(left);
         box.y = BOX_W'(top);
         box.w = BOX_W'(right - left);
         box.h = BOX_W'(bottom - top);
      end
      restart_tracking();
      return 1'b1;
   endfunction

   function automatic void pick_shape();
      int w, h;
      w = eff_dim(cfg_frame_w);
      h = eff_dim(cfg_frame_h);
      shape_noise = (forced_noise_pct >= 0) || ($urandom_range(0, 3) == 0);
      noise_pct   = (forced_noise_pct >= 0) ? forced_noise_pct : $urandom_range(0, 100);
      blob_r0     = $urandom_range(0, h - 1);
      blob_r1     = $urandom_range(blob_r0, h - 1);
      blob_c0     = $urandom_range(0, w - 1);
      blob_c1     = $urandom_range(blob_c0, w - 1);
      fill_pct    = $urandom_range(30, 100);
      stray_pct   = ($urandom_range(0, 3) == 0) ? 3 : 0;
   endfunction

   // Pixel for the current raster position: noise, or a partly filled rectangle with occasional stray pixels.
   function automatic logic [PIXEL_W-1:0] next_pixel();
      int roll;
      bit hit;
      if (col_pos == 0 && row_pos == 0) pick_shape();
      roll = $urandom_range(0, 99);
      if (shape_noise)
         hit = roll < noise_pct;
      else if (row_pos >= blob_r0 && row_pos <= blob_r1 && col_pos >= blob_c0 && col_pos <= blob_c1)
         hit = roll < fill_pct;
      else
         hit = roll < stray_pct;
      return hit ? PIXEL_W'($urandom_range(1, 255)) : '0;
   endfunction

   function automatic int reg_bits(input csr_index_type idx);
      case (idx)
         CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT: return DIM_REG_W;
         CSR_EXTEND_PIXELS:                 return EXT_REG_W;
         default:                           return 1;
      endcase
   endfunction

   function automatic int reg_value(input csr_index_type idx);
      case (idx)
         CSR_FRAME_WIDTH:   return cfg_frame_w;
         CSR_FRAME_HEIGHT:  return cfg_frame_h;
         CSR_EXTEND_PIXELS: return cfg_extend;
         default:           return cfg_border;
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1);
         6:       return $urandom_range(9, 16);
         7:       return 2;
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   function automatic int pick_extend();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return $urandom_range(0, 3);
         3:       return 2047;
         default: return $urandom_range(0, 2047);
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      mask_box_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_boxes.size() == 0) begin
            $error("box received with none outstanding");
            error_count++;
         end else begin
            want = pending_boxes.pop_front();
            check_field("box_x", want.x, rsp_box_x);
            check_field("box_y", want.y, rsp_box_y);
            check_field("box_width", want.w, rsp_box_width);
            check_field("box_height", want.h, rsp_box_height);
            check_field("box_empty", want.empty, rsp_box_empty);
            boxes_checked++;
         end
      end
   end

   // result side: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Called at a falling edge; returns at a falling edge with req_valid still driven high.
   task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic use_typed,
                             input mask_box_type typed_box);
      mask_box_type box;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      if (predict_pixel(px, box)) pending_boxes.push_back(use_typed ? typed_box : box);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      // junk above the register width must be dropped
      if ($urandom_range(0, 3) == 0) data = data | ($urandom() << reg_bits(idx));
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_frame_w = data[DIM_REG_W-1:0];
            restart_tracking();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_frame_h = data[DIM_REG_W-1:0];
            restart_tracking();
         end
         CSR_EXTEND_PIXELS:   cfg_extend = data[EXT_REG_W-1:0];
         CSR_EMPTY_ON_BORDER: cfg_border = data[0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_reg(input csr_index_type idx, input int want);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field(idx.name(), want, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Lets every outstanding box out, plus the pipeline depth for trailing pixels.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int w, h, ext, brd, input bit geo, input int hold,
                            input int n_items);
      drain_results();
      if (geo) begin
         write_reg(CSR_FRAME_WIDTH, w);
         write_reg(CSR_FRAME_HEIGHT, h);
      end
      write_reg(CSR_EXTEND_PIXELS, ext);
      write_reg(CSR_EMPTY_ON_BORDER, brd);
      check_reg(CSR_FRAME_WIDTH, reg_value(CSR_FRAME_WIDTH));
      check_reg(CSR_FRAME_HEIGHT, reg_value(CSR_FRAME_HEIGHT));
      check_reg(CSR_EXTEND_PIXELS, reg_value(CSR_EXTEND_PIXELS));
      check_reg(CSR_EMPTY_ON_BORDER, reg_value(CSR_EMPTY_ON_BORDER));
      if (hold > 0) begin
         @(posedge clock);
         stall_left = hold;
         @(negedge clock);
      end
      repeat (n_items) push_pixel(next_pixel(), 1'b0, NO_BOX);
      phases_run++;
   endtask

   initial begin
      step_type cur_step;
      int       random_items, phase, w, h, ext, brd, per_frame, n_items, hold;
      bit       geo;

      restart_tracking();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         cur_step = directed_steps[i];
         case (cur_step.kind)
            STEP_READ: begin
               drain_results();
               check_reg(cur_step.target, cur_step.value);
            end
            STEP_WRITE: begin
               drain_results();
               write_reg(cur_step.target, cur_step.value);
            end
            default: push_pixel(cur_step.value[PIXEL_W-1:0], cur_step.typed, cur_step.box);
         endcase
      end

      // tiny frames behind a long result hold-off: the unit must back-pressure requests
      run_phase(2, 2, 0, 0, 1'b1, 150, 200);

      // long thin frames, one each: wide and tall boxes
      send_idle_pct    = 26;
      recv_stall_pct   = 26;
      forced_noise_pct = 50;
      run_phase(WIDE_DIM, 2, 0, 0, 1'b1, 0, 2 * WIDE_DIM);
      run_phase(2, WIDE_DIM, 1, 0, 1'b1, 0, 2 * WIDE_DIM);
      forced_noise_pct = -1;

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         // keeping the geometry lets a part-finished frame carry on under new margins
         geo = (phase == 0) || ($urandom_range(0, 3) != 0);
         w   = pick_dim();
         h   = pick_dim();
         ext = pick_extend();
         brd = $urandom_range(0, 1);
         per_frame = geo ? eff_dim(w) * eff_dim(h) : eff_dim(cfg_frame_w) * eff_dim(cfg_frame_h);
         n_items = per_frame * (1 + $urandom_range(20, 160) / per_frame);
         if ($urandom_range(0, 2) == 0) n_items += $urandom_range(1, per_frame - 1);
         hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : 0;
         run_phase(w, h, ext, brd, geo, hold, n_items);
         random_items += n_items;
         phase++;
      end

      drain_results();
      $display("Sent %0d mask pixels over %0d register settings; %0d boxes checked.",
               items_sent, phases_run, boxes_checked);
      $display("Settings spanned clamped, minimal and long thin frames, margins 0..2047.");
      if (error_count == 0 && pending_boxes.size() == 0) begin
         $display("tb_mask_bounding_box_unit: PASS");
      end else begin
         $display("tb_mask_bounding_box_unit: FAIL");
      end
      $finish;
   end

endmodule
